// ----- src/multi_timer_bank_macros.svh -----
// ----------------------------------------------------------------------------
// multi_timer_bank_macros: assertion shorthands for the timer bank
// Clocked, reset-qualified implication checks reporting through $error.
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_BANK_MACROS_SVH
`define MULTI_TIMER_BANK_MACROS_SVH

// same-cycle implication
`define MTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mtb_pkg.sv -----
// ----------------------------------------------------------------------------
// mtb_pkg
// Command codes, sequencer states and fixed field widths of the timer bank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtb_pkg;

    localparam int CMD_W     = 3;
    localparam int INDEX_W   = 3;
    localparam int ACTIVE_W  = 4;
    localparam int RELOAD_W  = 32;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_START      = 3'd1,
        CMD_STOP       = 3'd2,
        CMD_SET_RELOAD = 3'd3,
        CMD_CONFIGURE  = 3'd4,
        CMD_PROCESS    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_FINISH
    } state_t;

endpackage

// ----- src/mtb_timer_alu.sv -----
// ----------------------------------------------------------------------------
// mtb_timer_alu
// Shared per-timer update (decrement, expiry compare, reload select, start,
// stop, reload/repeat loads) for the one timer entry the sequencer holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtb_timer_alu
    import mtb_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  cmd_t                            cmd,
    input  logic signed [COUNTER_WIDTH-1:0] count_in,
    input  logic signed [COUNTER_WIDTH-1:0] reload_in,
    input  logic                            repeat_in,
    input  logic signed [COUNTER_WIDTH-1:0] load_reload,
    input  logic                            load_repeat,
    output logic signed [COUNTER_WIDTH-1:0] count_out,
    output logic signed [COUNTER_WIDTH-1:0] reload_out,
    output logic                            repeat_out,
    output logic                            fire
);

    localparam logic [COUNTER_WIDTH-1:0] ONE = {{(COUNTER_WIDTH-1){1'b0}}, 1'b1};

    always_comb
    begin
        count_out  = count_in;
        reload_out = reload_in;
        repeat_out = repeat_in;
        fire       = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                // only positive counts run down; stopped and other negatives hold
                if (!count_in[COUNTER_WIDTH-1] && (count_in != '0))
                begin
                    count_out = count_in - ONE;
                end
            end
            CMD_PROCESS:
            begin
                if (count_in == '0)
                begin
                    fire      = 1'b1;
                    count_out = repeat_in ? reload_in : '1;
                end
            end
            CMD_START:
            begin
                count_out = reload_in;
            end
            CMD_STOP:
            begin
                count_out = '1;
            end
            CMD_SET_RELOAD:
            begin
                reload_out = load_reload;
            end
            CMD_CONFIGURE:
            begin
                reload_out = load_reload;
                repeat_out = load_repeat;
                count_out  = '1;
            end
            default:
            begin
                count_out = count_in;
            end
        endcase
    end

endmodule

// ----- src/multi_timer_bank.sv -----
// ----------------------------------------------------------------------------
// multi_timer_bank
// Bank of one-shot / periodic timers held in a small memory, updated one
// entry per cycle through a shared update unit under a scan sequencer.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  command   | start, busy (taken: !busy) | cmd, timer_index, reload_value,
//            |                            | repeat_flag
//  result    | result_valid (one cycle)   | fired, fired_index, last
//  config    | cfg_valid, cfg_ready       | cfg_data (active_timers)
//
//  Tick, over n = min(active_timers, NUM_TIMERS) timers: a memory read
//  lead-in, then one timer per cycle. Process: the same, then a finish state
//  (alone if none is active); a hit is held until the next hit or the scan
//  end, so a result leaves in the cycle after the next hit, the last from the
//  finish state. Start/stop/set reload/configure: read, then run. Ignored
//  commands and a tick with no active timer keep busy low. The active count
//  is taken only in an idle cycle without start. Reset clears the per-entry
//  valid bits at once, so no clearing pass runs. Results cannot be stalled.
//
`timescale 1ns / 1ps

`include "multi_timer_bank_macros.svh"

module multi_timer_bank
    import mtb_pkg::*;
#(
    parameter int NUM_TIMERS    = 8,
    parameter int COUNTER_WIDTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           cmd,
    input  logic [INDEX_W-1:0]         timer_index,
    input  logic signed [RELOAD_W-1:0] reload_value,
    input  logic                       repeat_flag,
    output logic                       result_valid,
    output logic                       fired,
    output logic [INDEX_W-1:0]         fired_index,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [ACTIVE_W-1:0]        cfg_data
);

    localparam int IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W   = $clog2(NUM_TIMERS + 1);
    localparam int ENTRY_W = 2 * COUNTER_WIDTH + 1;
    localparam longint RMAX = (longint'(1) <<< (COUNTER_WIDTH - 1)) - 64'sd1;
    localparam longint RMIN = -RMAX - 64'sd1;
    localparam logic [ENTRY_W-1:0] ENTRY_RESET = {1'b0, {(2*COUNTER_WIDTH){1'b1}}};

    // control
    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic                     pend_reg, pend_next;
    logic [INDEX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                     result_valid_reg, result_valid_next;
    logic [ACTIVE_W-1:0]      active_reg;
    logic [NUM_TIMERS-1:0]    vld_reg;

    // payload
    logic signed [COUNTER_WIDTH-1:0] reload_reg, reload_next;
    logic                     repeat_reg, repeat_next;
    logic                     fired_reg, fired_next;
    logic [INDEX_W-1:0]       fired_index_reg, fired_index_next;
    logic                     last_reg, last_next;

    // timer store
    logic [ENTRY_W-1:0]       mem [NUM_TIMERS];
    logic [ENTRY_W-1:0]       rd_data_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [ENTRY_W-1:0]       wr_data;
    logic [ENTRY_W-1:0]       entry;

    logic [CNT_W-1:0]         eff_n;
    logic                     accept;
    longint                   reload_wide;
    logic signed [COUNTER_WIDTH-1:0] reload_clamped;

    logic signed [COUNTER_WIDTH-1:0] alu_count, alu_reload;
    logic                     alu_repeat, alu_fire;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    // hold off the active count while a command is being taken
    assign cfg_ready = (state_reg == ST_IDLE) && !start;

    assign result_valid = result_valid_reg;
    assign fired        = fired_reg;
    assign fired_index  = fired_index_reg;
    assign last         = last_reg;

    assign eff_n = (32'(active_reg) > NUM_TIMERS) ? CNT_W'(NUM_TIMERS) : CNT_W'(active_reg);

    // saturate the reload into the counter range
    assign reload_wide    = longint'(reload_value);
    assign reload_clamped = (reload_wide > RMAX) ? COUNTER_WIDTH'(RMAX) :
                            (reload_wide < RMIN) ? COUNTER_WIDTH'(RMIN) :
                            COUNTER_WIDTH'(reload_wide);

    // never-written entries read as stopped
    assign entry = rd_vld_reg ? rd_data_reg : ENTRY_RESET;

    mtb_timer_alu #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_alu (
        .cmd         (cmd_reg),
        .count_in    (entry[COUNTER_WIDTH-1:0]),
        .reload_in   (entry[2*COUNTER_WIDTH-1:COUNTER_WIDTH]),
        .repeat_in   (entry[ENTRY_W-1]),
        .load_reload (reload_reg),
        .load_repeat (repeat_reg),
        .count_out   (alu_count),
        .reload_out  (alu_reload),
        .repeat_out  (alu_repeat),
        .fire        (alu_fire)
    );

    assign wr_data = {alu_repeat, alu_reload, alu_count};

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        ptr_next          = ptr_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        reload_next       = reload_reg;
        repeat_next       = repeat_reg;
        result_valid_next = 1'b0;
        fired_next        = fired_reg;
        fired_index_next  = fired_index_reg;
        last_next         = last_reg;
        rd_addr           = ptr_reg;
        wr_en             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd_t'(cmd);
                    reload_next = reload_clamped;
                    repeat_next = repeat_flag;
                    pend_next   = 1'b0;
                    case (cmd_t'(cmd))
                        CMD_TICK, CMD_PROCESS:
                        begin
                            ptr_next = '0;
                            if (eff_n != '0)
                            begin
                                state_next = ST_READ;
                            end
                            else if (cmd_t'(cmd) == CMD_PROCESS)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        CMD_START, CMD_STOP, CMD_SET_RELOAD, CMD_CONFIGURE:
                        begin
                            ptr_next = IDX_W'(timer_index);
                            // drop commands aimed past the active timers
                            if (32'(timer_index) < 32'(eff_n))
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rd_addr    = ptr_reg;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                wr_en   = 1'b1;
                // fetch the next entry while this one is written back
                rd_addr = ptr_reg + IDX_W'(1);
                if ((cmd_reg == CMD_PROCESS) && alu_fire)
                begin
                    // hold the newest hit until we know whether it is the last
                    if (pend_reg)
                    begin
                        result_valid_next = 1'b1;
                        fired_next        = 1'b1;
                        fired_index_next  = pend_idx_reg;
                        last_next         = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = INDEX_W'(ptr_reg);
                end
                if (((cmd_reg == CMD_TICK) || (cmd_reg == CMD_PROCESS)) &&
                    ((CNT_W'(ptr_reg) + CNT_W'(1)) < eff_n))
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
                else if (cmd_reg == CMD_PROCESS)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                result_valid_next = 1'b1;
                fired_next        = pend_reg;
                fired_index_next  = pend_reg ? pend_idx_reg : '0;
                last_next         = 1'b1;
                pend_next         = 1'b0;
                state_next        = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= CMD_TICK;
            ptr_reg          <= '0;
            pend_reg         <= 1'b0;
            pend_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
            active_reg       <= ACTIVE_RESET;
            vld_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            ptr_reg          <= ptr_next;
            pend_reg         <= pend_next;
            pend_idx_reg     <= pend_idx_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (wr_en)
            begin
                vld_reg[ptr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        reload_reg      <= reload_next;
        repeat_reg      <= repeat_next;
        fired_reg       <= fired_next;
        fired_index_reg <= fired_index_next;
        last_reg        <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    `MTB_ASSERT_NOW(a_empty_scan_is_last, clk, rst_n, result_valid && !fired,
        last && (fired_index == '0), "empty scan result must be last with index zero")
    `MTB_ASSERT_NOW(a_result_only_from_process, clk, rst_n, result_valid,
        cmd_reg == CMD_PROCESS, "result strobe outside a process scan")
    `MTB_ASSERT_NOW(a_scan_ptr_in_range, clk, rst_n, state_reg == ST_RUN,
        (CNT_W'(ptr_reg) < eff_n), "scan pointer beyond active timers")
    `MTB_ASSERT_NEXT(a_gap_after_last, clk, rst_n, result_valid && last,
        !result_valid, "result follows the last one of a scan")

endmodule

// ----- verif/tb_multi_timer_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_timer_bank
// Sends timer commands and active-count writes into the timer bank, keeps a
// behavioral copy of all counters, reloads and repeat flags, and checks every
// process-scan result field by field against the copy.
// ----------------------------------------------------------------------------

module tb_multi_timer_bank;
    import mtb_pkg::*;

    localparam int NUM_TIMERS    = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int CFG_INTERVAL  = 40;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam logic signed [RELOAD_W-1:0] TIMER_STOPPED = -32'sd1;
    localparam logic signed [RELOAD_W-1:0] RELOAD_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [RELOAD_W-1:0] RELOAD_MIN    = 32'sh8000_0000;

    typedef struct packed {
        logic               fired;
        logic [INDEX_W-1:0] fire_index;
        logic               last;
    } timer_event_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       start        = 1'b0;
    logic                       busy;
    logic [CMD_W-1:0]           cmd          = CMD_TICK;
    logic [INDEX_W-1:0]         timer_index  = '0;
    logic signed [RELOAD_W-1:0] reload_value = '0;
    logic                       repeat_flag  = 1'b0;
    logic                       result_valid;
    logic                       fired;
    logic [INDEX_W-1:0]         fired_index;
    logic                       last;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [ACTIVE_W-1:0]        cfg_data     = ACTIVE_RESET;

    // behavioral copy of the bank
    logic signed [RELOAD_W-1:0] bank_count  [NUM_TIMERS];
    logic signed [RELOAD_W-1:0] bank_reload [NUM_TIMERS];
    logic                       bank_repeat [NUM_TIMERS];
    logic [ACTIVE_W-1:0]        bank_active;

    timer_event_t expected_events[$];

    int error_count     = 0;
    int items_sent      = 0;
    int effective_items = 0;
    int events_checked  = 0;
    int expiries_seen   = 0;
    int sender_idle_pct = 0;

    multi_timer_bank i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .timer_index  (timer_index),
        .reload_value (reload_value),
        .repeat_flag  (repeat_flag),
        .result_valid (result_valid),
        .fired        (fired),
        .fired_index  (fired_index),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_span();
        return (bank_active > NUM_TIMERS) ? NUM_TIMERS : int'(bank_active);
    endfunction

    // Update the bank copy for one item and queue the scan results it causes.
    // Returns 0 for spare command codes and for indexed commands past the active timers.
    function automatic bit bank_apply(input logic [CMD_W-1:0] op,
                                      input logic [INDEX_W-1:0] ti,
                                      input logic signed [RELOAD_W-1:0] rv,
                                      input logic rf);
        int           span;
        int           hits;
        int           k;
        timer_event_t ev;
        span = active_span();
        bank_apply = 1'b1;
        case (op)
            CMD_TICK:
            begin
                for (int i = 0; i < span; i++)
                begin
                    if (bank_count[i] > 0)
                        bank_count[i] = bank_count[i] - 1;
                end
            end
            CMD_PROCESS:
            begin
                hits = 0;
                for (int i = 0; i < span; i++)
                begin
                    if (bank_count[i] == 0)
                        hits++;
                end
                k = 0;
                for (int i = 0; i < span; i++)
                begin
                    if (bank_count[i] == 0)
                    begin
                        bank_count[i] = bank_repeat[i] ? bank_reload[i] : TIMER_STOPPED;
                        k++;
                        ev.fired      = 1'b1;
                        ev.fire_index = INDEX_W'(i);
                        ev.last       = (k == hits);
                        expected_events.push_back(ev);
                    end
                end
                if (hits == 0)
                begin
                    ev.fired      = 1'b0;
                    ev.fire_index = '0;
                    ev.last       = 1'b1;
                    expected_events.push_back(ev);
                end
            end
            default:
            begin
                if (int'(ti) >= span)
                    bank_apply = 1'b0;
                else
                begin
                    // counters are as wide as the reload field, so no saturation
                    case (op)
                        CMD_START:      bank_count[ti] = bank_reload[ti];
                        CMD_STOP:       bank_count[ti] = TIMER_STOPPED;
                        CMD_SET_RELOAD: bank_reload[ti] = rv;
                        CMD_CONFIGURE:
                        begin
                            bank_reload[ti] = rv;
                            bank_repeat[ti] = rf;
                            bank_count[ti]  = TIMER_STOPPED;
                        end
                        default:        bank_apply = 1'b0;
                    endcase
                end
            end
        endcase
    endfunction

    function automatic logic signed [RELOAD_W-1:0] random_reload();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, 5);
        else if (pick < 75)
            return TIMER_STOPPED;
        else if (pick < 82)
            return -$signed($urandom_range(2, 1000));
        else if (pick < 88)
            return RELOAD_MAX;
        else
            return $urandom();
    endfunction

    function automatic logic [ACTIVE_W-1:0] random_active();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        else if (pick < 12)
            return ACTIVE_W'($urandom_range(9, 15));
        else
            return ACTIVE_W'($urandom_range(1, 8));
    endfunction

    // Call at a rising edge; returns at the edge that takes the item.
    task automatic send_item(input logic [CMD_W-1:0] op,
                             input logic [INDEX_W-1:0] ti,
                             input logic signed [RELOAD_W-1:0] rv,
                             input logic rf);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= op;
        timer_index  <= ti;
        reload_value <= rv;
        repeat_flag  <= rf;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (bank_apply(op, ti, rv, rf))
            effective_items++;
    endtask

    // Drop start and wait until the bank has gone quiet.
    task automatic settle_bank();
        start <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_active_count(input logic [ACTIVE_W-1:0] value);
        settle_bank();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        bank_active = value;
    endtask

    task automatic send_random_item();
        logic [CMD_W-1:0]   op;
        logic [INDEX_W-1:0] ti;
        int                 pick;
        int                 span;
        pick = $urandom_range(0, 99);
        span = active_span();
        if (pick < 30)
            op = CMD_TICK;
        else if (pick < 48)
            op = CMD_PROCESS;
        else if (pick < 62)
            op = CMD_START;
        else if (pick < 74)
            op = CMD_CONFIGURE;
        else if (pick < 84)
            op = CMD_SET_RELOAD;
        else if (pick < 95)
            op = CMD_STOP;
        else
            op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
        if (span > 0 && $urandom_range(0, 99) < 85)
            ti = INDEX_W'($urandom_range(0, span - 1));
        else
            ti = INDEX_W'($urandom_range(0, 7));
        send_item(op, ti, random_reload(), 1'($urandom_range(0, 1)));
    endtask

    // Arm a few timers with short periods, tick them down and scan.
    task automatic arm_and_fire();
        int                 span;
        int                 armed;
        logic [INDEX_W-1:0] ti;
        span  = active_span();
        armed = $urandom_range(1, 3);
        for (int j = 0; j < armed; j++)
        begin
            ti = INDEX_W'((span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 7));
            send_item(CMD_CONFIGURE, ti, $urandom_range(0, 4), 1'($urandom_range(0, 1)));
            send_item(CMD_START, ti, random_reload(), 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(0, 5))
            send_item(CMD_TICK, INDEX_W'($urandom_range(0, 7)), $urandom(),
                      1'($urandom_range(0, 1)));
        send_item(CMD_PROCESS, INDEX_W'($urandom_range(0, 7)), $urandom(),
                  1'($urandom_range(0, 1)));
        if ($urandom_range(0, 99) < 30)
            send_item(CMD_PROCESS, INDEX_W'($urandom_range(0, 7)), $urandom(),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_reset_state();
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
    endtask

    task automatic test_one_shot_and_periodic();
        send_item(CMD_CONFIGURE, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_CONFIGURE, 3'd7, 32'sd1, 1'b1);
        send_item(CMD_START, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_START, 3'd7, 32'sd0, 1'b0);
        send_item(CMD_TICK, 3'd0, 32'sd0, 1'b0);
        // both expire: timer 0 stops, timer 7 reloads
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_STOP, 3'd7, 32'sd0, 1'b0);
    endtask

    task automatic test_special_values();
        send_item(CMD_SET_RELOAD, 3'd3, RELOAD_MAX, 1'b1);
        send_item(CMD_START, 3'd3, 32'sd0, 1'b1);
        // a negative count other than stopped never moves
        send_item(CMD_CONFIGURE, 3'd1, -32'sd5, 1'b1);
        send_item(CMD_START, 3'd1, 32'sd0, 1'b1);
        send_item(CMD_SET_RELOAD, 3'd2, RELOAD_MIN, 1'b0);
        send_item(CMD_START, 3'd2, 32'sd0, 1'b0);
        send_item(CMD_TICK, 3'd7, 32'sd0, 1'b1);
        send_item(CMD_PROCESS, 3'd7, 32'sd0, 1'b1);
        send_item(CMD_SPARE_A, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_SPARE_B, 3'd7, TIMER_STOPPED, 1'b1);
    endtask

    task automatic test_active_count();
        write_active_count(4'd2);
        send_item(CMD_START, 3'd5, 32'sd0, 1'b0);
        write_active_count(4'd0);
        send_item(CMD_TICK, 3'd0, 32'sd0, 1'b0);
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
        // above the bank size saturates to all timers
        write_active_count(4'd15);
        send_item(CMD_CONFIGURE, 3'd6, 32'sd0, 1'b0);
        send_item(CMD_START, 3'd6, 32'sd0, 1'b0);
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
        write_active_count(4'd1);
        send_item(CMD_PROCESS, 3'd0, 32'sd0, 1'b0);
        write_active_count(4'd8);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int budget);
        int goal;
        int next_cfg;
        sender_idle_pct = idle_pct;
        goal     = effective_items + budget;
        next_cfg = effective_items + CFG_INTERVAL;
        while (effective_items < goal)
        begin
            if (effective_items >= next_cfg)
            begin
                write_active_count(random_active());
                next_cfg = effective_items + CFG_INTERVAL;
            end
            if ($urandom_range(0, 99) < 60)
                arm_and_fire();
            else
                send_random_item();
        end
        settle_bank();
    endtask

    always @(posedge clk)
    begin
        timer_event_t want;
        if (rst_n && result_valid)
        begin
            if (expected_events.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: expected none, actual fired %0b index %0d last %0b",
                         $time, fired, fired_index, last);
            end
            else
            begin
                want = expected_events.pop_front();
                events_checked++;
                if (want.fired)
                    expiries_seen++;
                if (fired !== want.fired)
                begin
                    error_count++;
                    $display("%0t fired mismatch: expected %0b actual %0b",
                             $time, want.fired, fired);
                end
                if (fired_index !== want.fire_index)
                begin
                    error_count++;
                    $display("%0t fired_index mismatch: expected %0d actual %0d",
                             $time, want.fire_index, fired_index);
                end
                if (last !== want.last)
                begin
                    error_count++;
                    $display("%0t last mismatch: expected %0b actual %0b",
                             $time, want.last, last);
                end
            end
        end
    end

    initial
    begin
        int waited;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            bank_count[i]  = TIMER_STOPPED;
            bank_reload[i] = TIMER_STOPPED;
            bank_repeat[i] = 1'b0;
        end
        bank_active = ACTIVE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_one_shot_and_periodic();
        test_special_values();
        test_active_count();
        test_random_traffic(27, 110);
        test_random_traffic(70, 110);
        test_random_traffic(0, 100);

        start  <= 1'b0;
        waited = 0;
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            error_count++;
            $display("%0t %0d scan results never arrived", $time, expected_events.size());
        end

        $display("Run: %0d commands sent, %0d acted on, %0d scan results checked, %0d expiries.",
                 items_sent, effective_items, events_checked, expiries_seen);
        $display("Active count swept over 0, 1..8 and saturating values under three idle mixes.");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
